// ----- sv/pwjm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwjm_pkg
// Shared widths, constants and types of the periodic wakeup jitter monitor.
// ----------------------------------------------------------------------------
package pwjm_pkg;

    localparam int SEC_W  = 32;
    localparam int NSEC_W = 30;
    localparam int JIT_W  = 32;
    localparam int MISS_W = 31;
    localparam int CNT_W  = 32;
    localparam int ACC_W  = 32;

    localparam logic [ACC_W-1:0]  NS_PER_SEC  = ACC_W'(1_000_000_000);
    localparam logic [NSEC_W-1:0] NSEC_MAX    = NSEC_W'(999_999_999);
    localparam logic [NSEC_W-1:0] CYCLE_RESET = NSEC_W'(1_000_000);

    localparam int DIV_W   = MISS_W;
    localparam int DIV_CNT = $clog2(DIV_W);

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [NSEC_W-1:0] clamp_nsec(input logic [NSEC_W-1:0] v);
        return (v > NSEC_MAX) ? NSEC_MAX : v;
    endfunction

endpackage

// ----- sv/pwjm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwjm_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwjm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pwjm_pkg::DIV_W-1:0]    i_dividend,
    input  logic [pwjm_pkg::NSEC_W-1:0]   i_divisor,
    output pwjm_pkg::t_div_stat           o_stat,
    output logic [pwjm_pkg::DIV_W-1:0]    o_quot,
    output logic [pwjm_pkg::NSEC_W-1:0]   o_rem
);
    import pwjm_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DIV_CNT-1:0]  r_cnt;
    logic [DIV_W-1:0]    r_quo;
    logic [DIV_W-1:0]    r_rem;
    logic [NSEC_W-1:0]   r_dvs;
    logic [DIV_W-1:0]    c_trial;
    logic                c_ge;

    assign c_trial = {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
    assign c_ge    = c_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= c_ge ? (c_trial - {1'b0, r_dvs}) : c_trial;
            r_quo <= {r_quo[DIV_W-2:0], c_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;
    assign o_rem       = r_rem[NSEC_W-1:0];

endmodule

// ----- sv/periodic_wakeup_jitter_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_wakeup_jitter_monitor
// Measures wakeup jitter against a periodic target, counts missed periods
// and advances the target; raises a sticky overrun on a jump over a second.
// ----------------------------------------------------------------------------
// Sequence: idle, then the init carry steps on the first request, compare,
//   the serial divider when the wakeup is late, update, carry steps and
//   done; once halted, a request goes from idle straight to done.
// Only one request is in flight at a time; o_in_stall is high until the
//   sequencer is back in idle. A result may wait in the output reg.
// Reset: synchronous active low; clears target, counters, peak, halt flag
//   and sets the cycle register to 1 ms.
module periodic_wakeup_jitter_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pwjm_pkg::NSEC_W-1:0]   i_cfg_cycle_time_ns,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pwjm_pkg::SEC_W-1:0]    i_start_sec,
    input  logic [pwjm_pkg::NSEC_W-1:0]   i_start_nsec,
    input  logic [pwjm_pkg::SEC_W-1:0]    i_wake_sec,
    input  logic [pwjm_pkg::NSEC_W-1:0]   i_wake_nsec,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [pwjm_pkg::JIT_W-1:0] o_jitter_ns,
    output logic [pwjm_pkg::MISS_W-1:0]   o_missed_count,
    output logic [pwjm_pkg::CNT_W-1:0]    o_total_missed,
    output logic signed [pwjm_pkg::JIT_W-1:0] o_max_jitter_ns,
    output logic [pwjm_pkg::CNT_W-1:0]    o_cycle_number,
    output logic                          o_late_warning,
    output logic                          o_overrun_error,
    output logic [pwjm_pkg::SEC_W-1:0]    o_next_sec,
    output logic [pwjm_pkg::NSEC_W-1:0]   o_next_nsec
);
    import pwjm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_CARRY = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]              r_state, n_state;
    logic [NSEC_W-1:0]       r_cycle;
    logic [SEC_W-1:0]        r_tgt_sec, n_tgt_sec;
    logic [NSEC_W-1:0]       r_tgt_nsec, n_tgt_nsec;
    logic                    r_tgt_valid, n_tgt_valid;
    logic [JIT_W-1:0]        r_peak, n_peak;
    logic [CNT_W-1:0]        r_msum, n_msum;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_halted, n_halted;
    logic [SEC_W-1:0]        r_wsec, n_wsec;
    logic [NSEC_W-1:0]       r_wnsec, n_wnsec;
    logic [NSEC_W-1:0]       r_cyc, n_cyc;
    logic [JIT_W-1:0]        r_jit, n_jit;
    logic [MISS_W-1:0]       r_jpos, n_jpos;
    logic [MISS_W-1:0]       r_missed, n_missed;
    logic [NSEC_W-1:0]       r_rem, n_rem;
    logic                    r_late, n_late;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic                    r_out_valid;

    logic                    c_accept;
    logic [NSEC_W-1:0]       c_cyc_eff;
    logic [JIT_W-1:0]        c_diff;
    logic [JIT_W-1:0]        c_jit;
    logic                    c_match;
    logic [JIT_W-1:0]        c_abs_peak;
    logic [JIT_W-1:0]        c_abs_jit;
    logic [CNT_W:0]          c_sum;
    logic [MISS_W+3:0]       c_ten;
    logic                    c_load_out;
    logic                    w_div_start;
    t_div_stat               w_div_stat;
    logic [DIV_W-1:0]        w_div_quot;
    logic [NSEC_W-1:0]       w_div_rem;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign c_accept    = i_in_valid && !o_in_stall;
    assign c_load_out  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign c_cyc_eff = (r_cycle == '0) ? NSEC_W'(1) : clamp_nsec(r_cycle);

    assign c_diff = {2'b00, r_wnsec} - {2'b00, r_tgt_nsec};
    assign c_abs_peak = r_peak[JIT_W-1] ? (~r_peak + 1'b1) : r_peak;
    assign c_abs_jit  = r_jit[JIT_W-1] ? (~r_jit + 1'b1) : r_jit;
    assign c_sum = {1'b0, r_msum} + {2'b00, r_missed};
    assign c_ten = {r_jpos, 3'b000} + {2'b00, r_jpos, 1'b0};

    always_comb begin
        c_match = 1'b1;
        c_jit   = c_diff;
        if (r_wsec == r_tgt_sec) begin
            c_jit = c_diff;
        end else if (r_wsec == r_tgt_sec + 1'b1) begin
            c_jit = c_diff + NS_PER_SEC;
        end else if (r_wsec == r_tgt_sec - 1'b1) begin
            c_jit = c_diff - NS_PER_SEC;
        end else begin
            c_match = 1'b0;
        end
    end

    assign w_div_start = (r_state == S_CMP) && c_match && !c_jit[JIT_W-1] && (c_jit != '0);

    pwjm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (c_jit[DIV_W-1:0]),
        .i_divisor  (r_cyc),
        .o_stat     (w_div_stat),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_tgt_sec   = r_tgt_sec;
        n_tgt_nsec  = r_tgt_nsec;
        n_tgt_valid = r_tgt_valid;
        n_peak      = r_peak;
        n_msum      = r_msum;
        n_count     = r_count;
        n_halted    = r_halted;
        n_wsec      = r_wsec;
        n_wnsec     = r_wnsec;
        n_cyc       = r_cyc;
        n_jit       = r_jit;
        n_jpos      = r_jpos;
        n_missed    = r_missed;
        n_rem       = r_rem;
        n_late      = r_late;
        n_acc       = r_acc;
        unique case (r_state) inside
            S_IDLE: begin
                if (c_accept) begin
                    n_wsec   = i_wake_sec;
                    n_wnsec  = clamp_nsec(i_wake_nsec);
                    n_cyc    = c_cyc_eff;
                    n_jit    = '0;
                    n_jpos   = '0;
                    n_missed = '0;
                    n_rem    = '0;
                    n_late   = 1'b0;
                    if (r_halted) begin
                        n_state = S_DONE;
                    end else if (!r_tgt_valid) begin
                        n_tgt_sec   = i_start_sec;
                        n_tgt_valid = 1'b1;
                        n_acc       = {2'b00, clamp_nsec(i_start_nsec)} + {2'b00, c_cyc_eff};
                        n_state     = S_INIT;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_INIT, S_CARRY: begin
                if (r_acc >= NS_PER_SEC) begin
                    n_acc     = r_acc - NS_PER_SEC;
                    n_tgt_sec = r_tgt_sec + 1'b1;
                end else begin
                    n_tgt_nsec = r_acc[NSEC_W-1:0];
                    n_state    = (r_state == S_INIT) ? S_CMP : S_DONE;
                end
            end
            S_CMP: begin
                if (!c_match) begin
                    n_halted = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_jit = c_jit;
                    if (w_div_start) begin
                        n_jpos  = c_jit[MISS_W-1:0];
                        n_state = S_DIV;
                    end else begin
                        n_state = S_UPD;
                    end
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_missed = w_div_quot;
                    n_rem    = w_div_rem;
                    n_state  = S_UPD;
                end
            end
            S_UPD: begin
                if (c_abs_peak < c_abs_jit) begin
                    n_peak = r_jit;
                end
                n_msum  = c_sum[CNT_W] ? '1 : c_sum[CNT_W-1:0];
                n_late  = (r_missed == '0) && (r_jpos != '0)
                          && (c_ten > {5'b00000, r_cyc});
                n_acc   = {2'b00, r_tgt_nsec} + {1'b0, r_jpos} - {2'b00, r_rem}
                          + {2'b00, r_cyc};
                n_count = r_count + 1'b1;
                n_state = S_CARRY;
            end
            S_DONE: begin
                if (c_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cycle     <= CYCLE_RESET;
            r_tgt_sec   <= '0;
            r_tgt_nsec  <= '0;
            r_tgt_valid <= 1'b0;
            r_peak      <= '0;
            r_msum      <= '0;
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tgt_sec   <= n_tgt_sec;
            r_tgt_nsec  <= n_tgt_nsec;
            r_tgt_valid <= n_tgt_valid;
            r_peak      <= n_peak;
            r_msum      <= n_msum;
            r_count     <= n_count;
            r_halted    <= n_halted;
            if (i_cfg_valid) begin
                r_cycle <= i_cfg_cycle_time_ns;
            end
            if (c_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wsec   <= n_wsec;
        r_wnsec  <= n_wnsec;
        r_cyc    <= n_cyc;
        r_jit    <= n_jit;
        r_jpos   <= n_jpos;
        r_missed <= n_missed;
        r_rem    <= n_rem;
        r_late   <= n_late;
        r_acc    <= n_acc;
        if (c_load_out) begin
            o_jitter_ns     <= r_jit;
            o_missed_count  <= r_missed;
            o_total_missed  <= r_msum;
            o_max_jitter_ns <= r_peak;
            o_cycle_number  <= r_count;
            o_late_warning  <= r_late;
            o_overrun_error <= r_halted;
            o_next_sec      <= r_tgt_sec;
            o_next_nsec     <= r_tgt_nsec;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/pwjm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwjm_checker
// Port-level checks of the periodic wakeup jitter monitor.
// ----------------------------------------------------------------------------
module pwjm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [pwjm_pkg::JIT_W-1:0]    o_jitter_ns,
    input  logic [pwjm_pkg::MISS_W-1:0]   o_missed_count,
    input  logic                          o_late_warning,
    input  logic                          o_overrun_error,
    input  logic [pwjm_pkg::NSEC_W-1:0]   o_next_nsec
);
    import pwjm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_jitter_ns)
            && $stable(o_next_nsec))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken without going busy");

    a_halt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overrun_error |-> o_jitter_ns == '0
            && o_missed_count == '0 && !o_late_warning)
        else $error("halted result carries jitter");

    a_late_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_late_warning |-> o_missed_count == '0
            && !o_jitter_ns[JIT_W-1] && o_jitter_ns != '0)
        else $error("late warning with miss or non-positive jitter");

    a_nsec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_next_nsec <= NSEC_MAX)
        else $error("target nanoseconds out of range");

endmodule

bind periodic_wakeup_jitter_monitor pwjm_checker u_pwjm_checker (.*);

// ----- tb/tb_periodic_wakeup_jitter_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_wakeup_jitter_monitor
// Self-checking bench for the wakeup jitter monitor. Wakeup requests are
// built around the target time held by a local model of the monitor, so
// most land within a period or a few of the target, across several period
// settings. Results are checked field by field against the model, with
// random gaps and output stalls. The run ends with missed-sum saturation
// and the sticky overrun.
// ----------------------------------------------------------------------------
module tb_periodic_wakeup_jitter_monitor;

    import pwjm_pkg::*;

    localparam longint ONE_SEC_NS = 64'd1_000_000_000;
    localparam longint NSEC_TOP   = 64'd999_999_999;
    localparam int     SETTLE_CYC = 50;

    typedef struct {
        logic signed [JIT_W-1:0]  jitter;
        logic [MISS_W-1:0]        missed;
        logic [CNT_W-1:0]         total;
        logic signed [JIT_W-1:0]  peak;
        logic [CNT_W-1:0]         count;
        logic                     late;
        logic                     overrun;
        logic [SEC_W-1:0]         nxt_sec;
        logic [NSEC_W-1:0]        nxt_nsec;
    } t_wake_report;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [NSEC_W-1:0]        i_cfg_cycle_time_ns;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [SEC_W-1:0]         i_start_sec;
    logic [NSEC_W-1:0]        i_start_nsec;
    logic [SEC_W-1:0]         i_wake_sec;
    logic [NSEC_W-1:0]        i_wake_nsec;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [JIT_W-1:0]  o_jitter_ns;
    logic [MISS_W-1:0]        o_missed_count;
    logic [CNT_W-1:0]         o_total_missed;
    logic signed [JIT_W-1:0]  o_max_jitter_ns;
    logic [CNT_W-1:0]         o_cycle_number;
    logic                     o_late_warning;
    logic                     o_overrun_error;
    logic [SEC_W-1:0]         o_next_sec;
    logic [NSEC_W-1:0]        o_next_nsec;

    // model of the monitor
    logic [NSEC_W-1:0]  mon_period;
    logic [SEC_W-1:0]   mon_tgt_sec;
    logic [NSEC_W-1:0]  mon_tgt_nsec;
    logic               mon_tgt_set;
    longint             mon_peak;
    longint unsigned    mon_missed_sum;
    logic [CNT_W-1:0]   mon_count;
    logic               mon_halted;

    t_wake_report expected_reports[$];

    logic quiet = 1'b0;
    int   err_count = 0;
    int   n_sent = 0;
    int   n_checked = 0;
    int   n_periods = 0;

    periodic_wakeup_jitter_monitor dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_cycle_time_ns (i_cfg_cycle_time_ns),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_start_sec         (i_start_sec),
        .i_start_nsec        (i_start_nsec),
        .i_wake_sec          (i_wake_sec),
        .i_wake_nsec         (i_wake_nsec),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_jitter_ns         (o_jitter_ns),
        .o_missed_count      (o_missed_count),
        .o_total_missed      (o_total_missed),
        .o_max_jitter_ns     (o_max_jitter_ns),
        .o_cycle_number      (o_cycle_number),
        .o_late_warning      (o_late_warning),
        .o_overrun_error     (o_overrun_error),
        .o_next_sec          (o_next_sec),
        .o_next_nsec         (o_next_nsec)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint eff_period();
        if (mon_period == '0) begin
            return 1;
        end
        return (longint'(mon_period) > NSEC_TOP) ? NSEC_TOP : longint'(mon_period);
    endfunction

    function automatic longint sat_nsec(input logic [NSEC_W-1:0] v);
        return (longint'(v) > NSEC_TOP) ? NSEC_TOP : longint'(v);
    endfunction

    task automatic step_target(input longint unsigned ns);
        longint unsigned sum;
        sum = longint'(mon_tgt_nsec) + ns;
        mon_tgt_sec  = mon_tgt_sec + SEC_W'(sum / ONE_SEC_NS);
        mon_tgt_nsec = NSEC_W'(sum % ONE_SEC_NS);
    endtask

    task automatic predict_wakeup_report(input logic [SEC_W-1:0] ss,
                                         input logic [NSEC_W-1:0] sn,
                                         input logic [SEC_W-1:0] ws,
                                         input logic [NSEC_W-1:0] wn);
        longint          cyc;
        longint          jit;
        longint          wake_ns;
        longint          tgt_ns;
        longint unsigned miss;
        logic            late;
        logic [SEC_W-1:0] sec_ahead;
        logic [SEC_W-1:0] sec_behind;
        t_wake_report    r;
        cyc  = eff_period();
        jit  = 0;
        miss = 0;
        late = 1'b0;
        if (!mon_halted) begin
            wake_ns = sat_nsec(wn);
            if (!mon_tgt_set) begin
                mon_tgt_sec  = ss;
                mon_tgt_nsec = NSEC_W'(sat_nsec(sn));
                mon_tgt_set  = 1'b1;
                step_target(cyc);
            end
            tgt_ns     = longint'(mon_tgt_nsec);
            sec_ahead  = mon_tgt_sec + 1'b1;
            sec_behind = mon_tgt_sec - 1'b1;
            if (ws == mon_tgt_sec) begin
                jit = wake_ns - tgt_ns;
            end else if (ws == sec_ahead) begin
                jit = wake_ns + ONE_SEC_NS - tgt_ns;
            end else if (ws == sec_behind) begin
                jit = wake_ns - ONE_SEC_NS - tgt_ns;
            end else begin
                mon_halted = 1'b1;
            end
            if (!mon_halted) begin
                if ((mon_peak < 0 ? -mon_peak : mon_peak) < (jit < 0 ? -jit : jit)) begin
                    mon_peak = jit;
                end
                if (jit > 0) begin
                    miss = jit / cyc;
                end
                mon_missed_sum = mon_missed_sum + miss;
                if (mon_missed_sum > 64'hFFFF_FFFF) begin
                    mon_missed_sum = 64'hFFFF_FFFF;
                end
                late = (miss == 0) && (jit > 0) && (jit > cyc / 10);
                step_target((miss + 1) * cyc);
                mon_count = mon_count + 1'b1;
            end
        end
        r.jitter   = JIT_W'(jit);
        r.missed   = MISS_W'(miss);
        r.total    = CNT_W'(mon_missed_sum);
        r.peak     = JIT_W'(mon_peak);
        r.count    = mon_count;
        r.late     = late;
        r.overrun  = mon_halted;
        r.nxt_sec  = mon_tgt_sec;
        r.nxt_nsec = mon_tgt_nsec;
        expected_reports.push_back(r);
    endtask

    // leaves i_in_valid high after the accept; callers lower it when they pause
    task automatic send_wakeup(input logic [SEC_W-1:0] ss, input logic [NSEC_W-1:0] sn,
                               input logic [SEC_W-1:0] ws, input logic [NSEC_W-1:0] wn);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_sec  <= ss;
        i_start_nsec <= sn;
        i_wake_sec   <= ws;
        i_wake_nsec  <= wn;
        do @(posedge i_clk); while (o_in_stall);
        predict_wakeup_report(ss, sn, ws, wn);
        n_sent++;
    endtask

    // wakeup at target + off, kept within one second of the target seconds
    task automatic send_offset(input longint off);
        longint            pos;
        logic [SEC_W-1:0]  ws;
        logic [NSEC_W-1:0] wn;
        pos = longint'(mon_tgt_nsec) + off;
        if (pos < -ONE_SEC_NS) begin
            pos = -ONE_SEC_NS;
        end
        if (pos > 2 * ONE_SEC_NS - 1) begin
            pos = 2 * ONE_SEC_NS - 1;
        end
        if (pos < 0) begin
            ws = mon_tgt_sec - 1'b1;
            wn = NSEC_W'(pos + ONE_SEC_NS);
        end else if (pos >= ONE_SEC_NS) begin
            ws = mon_tgt_sec + 1'b1;
            wn = NSEC_W'(pos - ONE_SEC_NS);
        end else begin
            ws = mon_tgt_sec;
            wn = NSEC_W'(pos);
        end
        send_wakeup($urandom, NSEC_W'($urandom), ws, wn);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [NSEC_W-1:0] v);
        wait_drain();
        i_cfg_valid         <= 1'b1;
        i_cfg_cycle_time_ns <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        mon_period = v;
        n_periods++;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic longint pick_offset(input longint cyc);
        longint span;
        span = (cyc * 8 > 64'd1_900_000_000) ? 64'd1_900_000_000 : cyc * 8;
        case ($urandom_range(0, 9)) inside
            0, 1: return -longint'($urandom_range(0, int'(cyc)));
            2: return longint'($urandom_range(0, 2)) - 1;
            3, 4: return longint'($urandom_range(0, int'(cyc / 10)));
            5: begin
                case ($urandom_range(0, 4))
                    0: return cyc / 10;
                    1: return cyc / 10 + 1;
                    2: return cyc - 1;
                    3: return cyc;
                    default: return 2 * cyc;
                endcase
            end
            6, 7: return longint'($urandom_range(int'(cyc / 10), int'(cyc)));
            8: return longint'($urandom_range(int'(cyc), int'(span)));
            default: return longint'($urandom_range(0, 32'd2_999_999_999)) - ONE_SEC_NS;
        endcase
    endfunction

    task automatic send_random_wakeup();
        logic [SEC_W-1:0] ws;
        case ($urandom_range(0, 2))
            0: ws = mon_tgt_sec - 1'b1;
            1: ws = mon_tgt_sec;
            default: ws = mon_tgt_sec + 1'b1;
        endcase
        case ($urandom_range(0, 19))
            0: send_wakeup($urandom, NSEC_W'($urandom), ws,
                           NSEC_W'($urandom_range(1_000_000_000, 30'h3FFF_FFFF)));
            1: send_wakeup($urandom, NSEC_W'($urandom), ws, NSEC_W'($urandom));
            default: send_offset(pick_offset(eff_period()));
        endcase
    endtask

    // ------------------------------------------------------------------------

    task automatic test_first_wakeup_wrap();
        // target = all-ones seconds + saturated nsec + 1 ms, wraps to second 0
        send_wakeup(32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        send_offset(0);
    endtask

    task automatic test_warning_threshold();
        longint cyc;
        cyc = eff_period();
        send_offset(cyc / 10);
        send_offset(cyc / 10 + 1);
        send_offset(cyc - 1);
        send_offset(cyc);
        send_offset(3 * cyc + 7);
        send_offset(-1);
    endtask

    task automatic test_nsec_saturation();
        send_wakeup($urandom, 30'h3FFF_FFFF, mon_tgt_sec, 30'h3FFF_FFFF);
        send_wakeup($urandom, 30'h3FFF_FFFF, mon_tgt_sec + 1'b1, 30'h3FFF_FFFF);
        send_wakeup(32'h0, 30'h0, mon_tgt_sec - 1'b1, 30'h0);
    endtask

    task automatic test_period_extremes();
        write_period('0);
        send_offset(0);
        send_offset(5);
        write_period(30'h3FFF_FFFF);
        send_offset(eff_period());
        send_offset(-1);
        write_period(NSEC_W'(999_999_999));
        send_offset(eff_period() / 10 + 1);
        write_period(NSEC_W'(1));
        send_offset(1);
    endtask

    task automatic test_random_phases();
        logic [NSEC_W-1:0] periods[8];
        periods[0] = CYCLE_RESET;
        periods[1] = NSEC_W'(1);
        periods[2] = NSEC_W'(999_999_999);
        periods[3] = NSEC_W'($urandom_range(2, 1000));
        periods[4] = NSEC_W'($urandom);
        periods[5] = '0;
        periods[6] = 30'h3FFF_FFFF;
        periods[7] = NSEC_W'($urandom_range(1000, 2_000_000));
        for (int p = 0; p < 8; p++) begin
            write_period(periods[p]);
            if (p == 7) begin
                quiet = 1'b1;
            end
            repeat (250) send_random_wakeup();
        end
    endtask

    task automatic test_missed_saturation();
        write_period(NSEC_W'(1));
        repeat (4) send_offset(64'd1_999_999_999);
        send_offset(-3);
    endtask

    task automatic test_overrun_halt();
        send_wakeup($urandom, NSEC_W'($urandom), mon_tgt_sec + 32'd2, NSEC_W'($urandom));
        send_offset(0);
        send_offset(eff_period() + 1);
        send_wakeup($urandom, NSEC_W'($urandom), $urandom, NSEC_W'($urandom));
        write_period(NSEC_W'(5000));
        send_offset(5001);
    endtask

    // ------------------------------------------------------------------------

    initial begin : stall_gen
        int unsigned hold;
        hold = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                hold = $urandom_range(0, 4);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_wake_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                $error("result with no request outstanding");
                err_count++;
            end else begin
                want = expected_reports.pop_front();
                n_checked++;
                check_field("jitter_ns", want.jitter, o_jitter_ns);
                check_field("missed_count", want.missed, o_missed_count);
                check_field("total_missed", want.total, o_total_missed);
                check_field("max_jitter_ns", want.peak, o_max_jitter_ns);
                check_field("cycle_number", want.count, o_cycle_number);
                check_field("late_warning", want.late, o_late_warning);
                check_field("overrun_error", want.overrun, o_overrun_error);
                check_field("next_sec", want.nxt_sec, o_next_sec);
                check_field("next_nsec", want.nxt_nsec, o_next_nsec);
            end
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_cycle_time_ns = '0;
        i_in_valid          = 1'b0;
        i_start_sec         = '0;
        i_start_nsec        = '0;
        i_wake_sec          = '0;
        i_wake_nsec         = '0;
        mon_period          = CYCLE_RESET;
        mon_tgt_sec         = '0;
        mon_tgt_nsec        = '0;
        mon_tgt_set         = 1'b0;
        mon_peak            = 0;
        mon_missed_sum      = 0;
        mon_count           = '0;
        mon_halted          = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_wakeup_wrap();
        test_warning_threshold();
        test_nsec_saturation();
        test_period_extremes();
        test_random_phases();
        test_missed_saturation();
        test_overrun_halt();
        wait_drain();

        $display("Checked %0d results from %0d wakeup requests over %0d period writes,",
                 n_checked, n_sent, n_periods);
        $display("including second wrap, nsec saturation, missed-sum saturation and halt.");
        if (err_count == 0 && expected_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
